// File: hw/rtl/csp_pkg.sv
package csp_pkg;

    // format_select codes
    localparam logic [1:0] FMT_HEX6 = 2'd0;
    localparam logic [1:0] FMT_HEX3 = 2'd1;
    localparam logic [1:0] FMT_RGB  = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 4;

    // character codes
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_UA     = 8'd65;
    localparam logic [7:0] CH_UF     = 8'd70;
    localparam logic [7:0] CH_LA     = 8'd97;
    localparam logic [7:0] CH_LF     = 8'd102;
    localparam logic [7:0] CH_LB     = 8'd98;
    localparam logic [7:0] CH_LG     = 8'd103;
    localparam logic [7:0] CH_LR     = 8'd114;

    // one classified character as it sits in the queue
    typedef struct packed {
        logic       is_hash;
        logic       is_r;
        logic       is_g;
        logic       is_b;
        logic       is_lparen;
        logic       is_rparen;
        logic       is_comma;
        logic       is_space;
        logic       is_digit;
        logic       is_hex;
        logic [3:0] nib;
        logic       last;
    } t_char_info;

    function automatic t_char_info classify(input logic [7:0] c, input logic last);
        t_char_info info;
        logic [7:0] ofs;
        info           = '0;
        ofs            = 8'd0;
        info.is_hash   = (c == CH_HASH);
        info.is_r      = (c == CH_LR);
        info.is_g      = (c == CH_LG);
        info.is_b      = (c == CH_LB);
        info.is_lparen = (c == CH_LPAREN);
        info.is_rparen = (c == CH_RPAREN);
        info.is_comma  = (c == CH_COMMA);
        info.is_space  = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
        info.is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        info.last      = last;
        if (info.is_digit) begin
            ofs         = c - CH_ZERO;
            info.is_hex = 1'b1;
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            ofs         = c - CH_LA + 8'd10;
            info.is_hex = 1'b1;
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            ofs         = c - CH_UA + 8'd10;
            info.is_hex = 1'b1;
        end
        info.nib = ofs[3:0];
        return info;
    endfunction

endpackage

// File: hw/rtl/csp_front.sv
module csp_front
    import csp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_q_valid,
    output t_char_info o_q_item,
    input  logic       i_q_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_char_info        r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              push, pop;

    assign o_ready   = (r_count != CW'(DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    // classify on the way in so the back end only sees flags
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= classify(i_char_code, i_last_char);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/csp_back.sv
module csp_back
    import csp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_fmt,
    input  logic        i_clear,
    input  logic        i_q_valid,
    input  t_char_info  i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_matched,
    output logic [31:0] o_first_value,
    output logic [31:0] o_second_value,
    output logic [31:0] o_third_value
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_G      = 3'd1;
    localparam logic [2:0] PH_B      = 3'd2;
    localparam logic [2:0] PH_PAREN  = 3'd3;
    localparam logic [2:0] PH_HEX    = 3'd4;
    localparam logic [2:0] PH_LEAD   = 3'd5;
    localparam logic [2:0] PH_DIGITS = 3'd6;
    localparam logic [2:0] PH_TRAIL  = 3'd7;

    localparam logic [1:0] DEC_NONE  = 2'd0;
    localparam logic [1:0] DEC_MATCH = 2'd1;
    localparam logic [1:0] DEC_FAIL  = 2'd2;

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic        r_cnt, n_cnt;
    logic [1:0]  r_dec, n_dec;
    logic [31:0] r_store [3];
    logic [31:0] n_store [3];
    logic        r_out_valid;
    logic        r_matched;
    logic [31:0] r_val [3];

    logic        pop;
    logic        wr_en;
    logic [31:0] wr_val;
    logic [31:0] cur;
    logic        ok;
    t_char_info  it;

    assign it = i_q_item;
    // a last character needs the output slot free or draining
    assign pop     = i_q_valid && (!it.last || !r_out_valid || i_out_ready);
    assign o_q_pop = pop;

    always_comb begin
        unique case (r_idx)
            2'd0:    cur = r_store[0];
            2'd1:    cur = r_store[1];
            default: cur = r_store[2];
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_dec   = r_dec;
        wr_en   = 1'b0;
        wr_val  = {28'd0, it.nib};
        if (r_dec == DEC_NONE) begin
            unique case (r_phase)
                PH_START: begin
                    if ((i_fmt == FMT_HEX6 || i_fmt == FMT_HEX3) && it.is_hash) begin
                        n_phase = PH_HEX;
                    end else if (i_fmt == FMT_RGB && it.is_r) begin
                        n_phase = PH_G;
                    end else begin
                        n_dec = DEC_FAIL;
                    end
                end
                PH_G: begin
                    if (it.is_g) n_phase = PH_B; else n_dec = DEC_FAIL;
                end
                PH_B: begin
                    if (it.is_b) n_phase = PH_PAREN; else n_dec = DEC_FAIL;
                end
                PH_PAREN: begin
                    if (it.is_lparen) begin
                        n_phase = PH_LEAD;
                        n_idx   = 2'd0;
                    end else begin
                        n_dec = DEC_FAIL;
                    end
                end
                PH_HEX: begin
                    if (!it.is_hex) begin
                        n_dec = DEC_FAIL;
                    end else begin
                        wr_en  = 1'b1;
                        wr_val = {cur[27:0], it.nib};
                        if (i_fmt == FMT_HEX6 && !r_cnt) begin
                            n_cnt = 1'b1;
                        end else begin
                            n_cnt = 1'b0;
                            if (r_idx == 2'd2) n_dec = DEC_MATCH;
                            else               n_idx = r_idx + 2'd1;
                        end
                    end
                end
                PH_LEAD: begin
                    if (it.is_digit) begin
                        wr_en   = 1'b1;
                        n_phase = PH_DIGITS;
                    end else if (!it.is_space) begin
                        n_dec = DEC_FAIL;
                    end
                end
                PH_DIGITS, PH_TRAIL: begin
                    if (r_phase == PH_DIGITS && it.is_digit) begin
                        wr_en  = 1'b1;
                        wr_val = (cur << 3) + (cur << 1) + {28'd0, it.nib};
                    end else if (it.is_space) begin
                        n_phase = PH_TRAIL;
                    end else if (r_idx != 2'd2 && it.is_comma) begin
                        n_idx   = r_idx + 2'd1;
                        n_phase = PH_LEAD;
                    end else if (r_idx == 2'd2 && it.is_rparen) begin
                        n_dec = DEC_MATCH;
                    end else begin
                        n_dec = DEC_FAIL;
                    end
                end
                default: n_dec = DEC_FAIL;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_store[k] = (wr_en && r_idx == 2'(k)) ? wr_val : r_store[k];
        end
    end

    assign ok = (n_dec == DEC_MATCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear || (pop && it.last)) begin
            r_phase <= PH_START;
            r_idx   <= 2'd0;
            r_cnt   <= 1'b0;
            r_dec   <= DEC_NONE;
            for (int k = 0; k < 3; k++) r_store[k] <= 32'd0;
        end else if (pop) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_dec   <= n_dec;
            for (int k = 0; k < 3; k++) r_store[k] <= n_store[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && it.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && it.last) begin
            r_matched <= ok;
            for (int k = 0; k < 3; k++) r_val[k] <= ok ? n_store[k] : 32'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_matched      = r_matched;
    assign o_first_value  = r_val[0];
    assign o_second_value = r_val[1];
    assign o_third_value  = r_val[2];

endmodule

// File: hw/rtl/color_string_parser.sv
// A transferred character is queued and reaches the parser at the queue head;
// the result of a last character is on o_out_valid right after the edge that pops it.
// The parser takes one character per cycle, with one multiply-by-ten add per step;
// a stalled output slot holds back only last characters.
// Reset (i_rst_n low, synchronous): format back to six-digit hex, queue emptied,
// parse state cleared, no result pending.
module color_string_parser
    import csp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    // character channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_matched,
    output logic [31:0] o_first_value,
    output logic [31:0] o_second_value,
    output logic [31:0] o_third_value
);

    logic [1:0] r_format;
    logic       q_valid;
    logic       q_pop;
    t_char_info q_item;

    // format register; a write also drops any string in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_HEX6;
        end else if (i_cfg_wr_en) begin
            r_format <= i_cfg_wr_data;
        end
    end

    // front: takes transfers, classifies each character, queues it
    csp_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    // back: format state machine, component accumulators, result register
    csp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fmt          (r_format),
        .i_clear        (i_cfg_wr_en),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_matched      (o_matched),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_third_value  (o_third_value)
    );

    // a pending result is never overwritten by the next string's end
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && q_pop) |-> !q_item.last)
        else $error("result overwritten while stalled");

    // failed strings report all-zero values
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_matched) |->
        (o_first_value == 32'd0 && o_second_value == 32'd0 && o_third_value == 32'd0))
        else $error("nonzero values on a failed string");

    // three-digit hex yields one nibble per component
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_matched && r_format == FMT_HEX3) |->
        (o_first_value < 32'd16 && o_second_value < 32'd16 && o_third_value < 32'd16))
        else $error("short hex component out of range");

endmodule
